[src/cwm_pkg.sv]
// cwm_pkg: widths, codes and sizes shared by the column winner match block
// and its channel interfaces. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cwm_pkg;

   localparam int MAX_UNITS   = 16;
   localparam int MAX_COLUMNS = 64;
   localparam int VALUE_W     = 16;

   localparam int UNIT_W   = $clog2(MAX_UNITS);
   localparam int COL_W    = $clog2(MAX_COLUMNS);
   localparam int ADDR_W   = 2 * UNIT_W;
   localparam int DEPTH    = MAX_UNITS * MAX_UNITS;
   localparam int COUNT_W  = 32;

   // configuration register widths and indexes
   localparam int UPC_W       = 5;
   localparam int CPP_W       = 7;
   localparam int CSR_DATA_W  = 7;
   localparam int CSR_INDEX_W = 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNITS_PER_COLUMN    = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLUMNS_PER_PATTERN = 1'd1;

   localparam logic [UPC_W-1:0] UPC_RESET = UPC_W'(MAX_UNITS);
   localparam logic [CPP_W-1:0] CPP_RESET = CPP_W'(1);

   typedef enum logic [1:0] {
      OP_PUSH       = 2'd0,
      OP_READ       = 2'd1,
      OP_READ_CLEAR = 2'd2
   } op_type;

   typedef enum logic {
      KIND_VERDICT = 1'b0,
      KIND_ENTRY   = 1'b1
   } kind_type;

endpackage

`default_nettype wire

[src/cwm_if.sv]
// cwm_req_if / cwm_rsp_if: valid/ready channels carrying one item or one result.
// Depends on cwm_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface cwm_req_if;
   import cwm_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [1:0]                operation;
   logic signed [VALUE_W-1:0] recalled_value;
   logic signed [VALUE_W-1:0] target_value;
   logic [UNIT_W-1:0]         entry_row;
   logic [UNIT_W-1:0]         entry_col;

   modport source (output valid, operation, recalled_value, target_value,
                   entry_row, entry_col, input ready);
   modport sink   (input valid, operation, recalled_value, target_value,
                   entry_row, entry_col, output ready);
endinterface

interface cwm_rsp_if;
   import cwm_pkg::*;

   logic               valid;
   logic               ready;
   logic               result_kind;
   logic [COL_W-1:0]   column_index;
   logic [UNIT_W-1:0]  recalled_winner;
   logic [UNIT_W-1:0]  target_winner;
   logic               column_match;
   logic               pattern_match;
   logic               pattern_done;
   logic [COUNT_W-1:0] entry_count;

   modport source (output valid, result_kind, column_index, recalled_winner,
                   target_winner, column_match, pattern_match, pattern_done,
                   entry_count, input ready);
   modport sink   (input valid, result_kind, column_index, recalled_winner,
                   target_winner, column_match, pattern_match, pattern_done,
                   entry_count, output ready);
endinterface

`default_nettype wire

[src/cwm_ram.sv]
// cwm_ram: generic single write port, single read port RAM with registered
// read data (old data on a same-address write). No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module cwm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[src/column_winner_match_confusion.sv]
// column_winner_match_confusion: per-column argmax of two streams, match
// verdicts and a 16x16 saturating confusion count store.
// Depends on cwm_pkg, cwm_if (channel interfaces) and cwm_ram.
//
//  channel   dir  handshake        beat
//  req_bus   in   valid/ready      operation, two Q8.8 values, entry row/col
//  rsp_bus   out  valid/ready      column verdict or confusion count
//  csr_*     in   write enable     register index, write data
//
// a beat is taken every cycle unless rsp_bus stalls; results go via s1_ff, rsp_ff
// the store read is issued on the accepting edge, the count update and
// write-back happen as the middle stage advances, forwarding the last write
// reset clears the trackers and the per-entry valid bits; no clearing pass
// a stalled result register holds the middle stage, which holds req_bus.ready

`timescale 1ns / 1ps
`default_nettype none

module column_winner_match_confusion (
   input  wire logic                           clock,
   input  wire logic                           reset,
   cwm_req_if.sink                             req_bus,
   cwm_rsp_if.source                           rsp_bus,
   input  wire logic                           csr_write_en,
   input  wire logic [cwm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [cwm_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import cwm_pkg::*;

   typedef struct packed {
      kind_type          kind;
      logic              clear;
      logic [ADDR_W-1:0] addr;
      logic              seen;
      logic [COL_W-1:0]  column_index;
      logic [UNIT_W-1:0] recalled_winner;
      logic [UNIT_W-1:0] target_winner;
      logic              column_match;
      logic              pattern_match;
      logic              pattern_done;
   } stage_type;

   // configuration
   logic [UPC_W-1:0] upc_ff;
   logic [CPP_W-1:0] cpp_ff;
   logic [UPC_W-1:0] units_eff;
   logic [CPP_W-1:0] cols_eff;

   // column tracking
   logic [UNIT_W-1:0]         unit_pos_ff, unit_pos_in;
   logic [COL_W-1:0]          col_pos_ff, col_pos_in;
   logic signed [VALUE_W-1:0] rbest_ff, rbest_in, tbest_ff, tbest_in;
   logic [UNIT_W-1:0]         ridx_ff, ridx_in, tidx_ff, tidx_in;
   logic                      match_ff, match_in;

   // accept stage
   logic      req_accept;
   op_type    op;
   logic      is_push, is_read, unit_last, col_last, col_match, pat_match;
   logic      stage_load;
   stage_type stage_in;
   stage_type s1_ff;
   logic      s1_valid_ff;
   logic      s1_adv;

   // store
   logic [DEPTH-1:0]   seen_ff;
   logic [COUNT_W-1:0] ram_rdata;
   logic               ram_we;
   logic [COUNT_W-1:0] wr_data;
   logic               lastwr_valid_ff;
   logic [ADDR_W-1:0]  lastwr_addr_ff;
   logic [COUNT_W-1:0] lastwr_data_ff;
   logic [COUNT_W-1:0] cur_count;

   // result register
   logic               rsp_valid_ff;
   stage_type          rsp_ff;
   logic [COUNT_W-1:0] rsp_count_ff;

   always_comb begin
      units_eff = upc_ff;
      if (upc_ff == '0) begin
         units_eff = UPC_W'(1);
      end else if (upc_ff > UPC_W'(MAX_UNITS)) begin
         units_eff = UPC_W'(MAX_UNITS);
      end
      cols_eff = cpp_ff;
      if (cpp_ff == '0) begin
         cols_eff = CPP_W'(1);
      end else if (cpp_ff > CPP_W'(MAX_COLUMNS)) begin
         cols_eff = CPP_W'(MAX_COLUMNS);
      end
   end

   assign s1_adv        = s1_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || s1_adv;
   assign req_accept    = req_bus.valid && req_bus.ready;

   always_comb begin
      op      = op_type'(req_bus.operation);
      is_push = 1'b0;
      is_read = 1'b0;
      unique case (op) inside
         OP_PUSH:                is_push = 1'b1;
         OP_READ, OP_READ_CLEAR: is_read = 1'b1;
         default:                ;
      endcase

      rbest_in = rbest_ff;
      ridx_in  = ridx_ff;
      tbest_in = tbest_ff;
      tidx_in  = tidx_ff;
      if (unit_pos_ff == '0) begin
         rbest_in = req_bus.recalled_value;
         ridx_in  = '0;
         tbest_in = req_bus.target_value;
         tidx_in  = '0;
      end else begin
         if (req_bus.recalled_value > rbest_ff) begin
            rbest_in = req_bus.recalled_value;
            ridx_in  = unit_pos_ff;
         end
         if (req_bus.target_value > tbest_ff) begin
            tbest_in = req_bus.target_value;
            tidx_in  = unit_pos_ff;
         end
      end

      // a column or pattern also ends when a register write left us past the end
      unit_last = ({1'b0, unit_pos_ff} + UPC_W'(1)) >= units_eff;
      col_last  = ({1'b0, col_pos_ff} + CPP_W'(1)) >= cols_eff;
      col_match = (ridx_in == tidx_in);
      pat_match = match_ff && col_match;

      unit_pos_in = unit_last ? '0 : unit_pos_ff + UNIT_W'(1);
      col_pos_in  = col_pos_ff;
      match_in    = match_ff;
      if (unit_last) begin
         col_pos_in = col_last ? '0 : col_pos_ff + COL_W'(1);
         match_in   = col_last ? 1'b1 : pat_match;
      end

      stage_in = '0;
      if (is_read) begin
         stage_in.kind  = KIND_ENTRY;
         stage_in.clear = (op == OP_READ_CLEAR);
         stage_in.addr  = {req_bus.entry_row, req_bus.entry_col};
      end else begin
         stage_in.kind            = KIND_VERDICT;
         stage_in.addr            = {ridx_in, tidx_in};
         stage_in.column_index    = col_pos_ff;
         stage_in.recalled_winner = ridx_in;
         stage_in.target_winner   = tidx_in;
         stage_in.column_match    = col_match;
         stage_in.pattern_match   = pat_match;
         stage_in.pattern_done    = col_last;
      end
      stage_in.seen = seen_ff[stage_in.addr];
      stage_load    = req_accept && (is_read || (is_push && unit_last));
   end

   cwm_ram #(
      .WIDTH (COUNT_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (s1_ff.addr),
      .wr_data (wr_data),
      .rd_en   (stage_load),
      .rd_addr (stage_in.addr),
      .rd_data (ram_rdata)
   );

   // count as of now: last write wins over the registered read
   always_comb begin
      if (lastwr_valid_ff && lastwr_addr_ff == s1_ff.addr) begin
         cur_count = lastwr_data_ff;
      end else if (s1_ff.seen) begin
         cur_count = ram_rdata;
      end else begin
         cur_count = '0;
      end
      if (s1_ff.kind == KIND_VERDICT) begin
         wr_data = (cur_count == '1) ? cur_count : cur_count + COUNT_W'(1);
      end else begin
         wr_data = '0;
      end
      ram_we = s1_adv && (s1_ff.kind == KIND_VERDICT || s1_ff.clear);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff          <= UPC_RESET;
         cpp_ff          <= CPP_RESET;
         unit_pos_ff     <= '0;
         col_pos_ff      <= '0;
         rbest_ff        <= '0;
         tbest_ff        <= '0;
         ridx_ff         <= '0;
         tidx_ff         <= '0;
         match_ff        <= 1'b1;
         s1_valid_ff     <= 1'b0;
         seen_ff         <= '0;
         lastwr_valid_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_UNITS_PER_COLUMN:    upc_ff <= csr_write_data[UPC_W-1:0];
               CSR_COLUMNS_PER_PATTERN: cpp_ff <= csr_write_data[CPP_W-1:0];
               default:                 ;
            endcase
         end
         if (req_accept && is_push) begin
            unit_pos_ff <= unit_pos_in;
            col_pos_ff  <= col_pos_in;
            rbest_ff    <= rbest_in;
            tbest_ff    <= tbest_in;
            ridx_ff     <= ridx_in;
            tidx_ff     <= tidx_in;
            match_ff    <= match_in;
         end
         if (stage_load) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (ram_we) begin
            seen_ff[s1_ff.addr] <= 1'b1;
            lastwr_valid_ff     <= 1'b1;
         end
         if (s1_adv) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (stage_load) begin
         s1_ff <= stage_in;
      end
      if (ram_we) begin
         lastwr_addr_ff <= s1_ff.addr;
         lastwr_data_ff <= wr_data;
      end
      if (s1_adv) begin
         rsp_ff       <= s1_ff;
         rsp_count_ff <= (s1_ff.kind == KIND_ENTRY) ? cur_count : '0;
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.result_kind     = rsp_ff.kind;
   assign rsp_bus.column_index    = rsp_ff.column_index;
   assign rsp_bus.recalled_winner = rsp_ff.recalled_winner;
   assign rsp_bus.target_winner   = rsp_ff.target_winner;
   assign rsp_bus.column_match    = rsp_ff.column_match;
   assign rsp_bus.pattern_match   = rsp_ff.pattern_match;
   assign rsp_bus.pattern_done    = rsp_ff.pattern_done;
   assign rsp_bus.entry_count     = rsp_count_ff;

   // a held middle stage keeps its address and blocks new beats
   a_stage_hold : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |=> s1_valid_ff && $stable(s1_ff.addr))
      else $error("middle stage lost its beat while stalled");

   a_no_overrun : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |-> !req_accept)
      else $error("beat accepted while middle stage blocked");

   a_verdict_match : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.kind == KIND_VERDICT |->
      rsp_ff.column_match == (rsp_ff.recalled_winner == rsp_ff.target_winner)
      && (!rsp_ff.pattern_match || rsp_ff.column_match) && rsp_count_ff == '0)
      else $error("verdict fields inconsistent");

   a_entry_clean : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.kind == KIND_ENTRY |->
      rsp_ff.column_index == '0 && !rsp_ff.column_match && !rsp_ff.pattern_match
      && !rsp_ff.pattern_done)
      else $error("entry read carries verdict fields");

   a_write_marks : assert property (@(posedge clock) disable iff (reset)
      ram_we |=> seen_ff[$past(s1_ff.addr)] && lastwr_valid_ff)
      else $error("store write not recorded");

endmodule

`default_nettype wire
